@@ src/tlvqp_pkg.sv @@
// Shared types, constants and the helper function of the TLV query parser.
package tlvqp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_VERSION_TYPE = 2'd0;
    localparam logic [1:0] REG_SIZE_TYPE    = 2'd1;
    localparam logic [1:0] REG_GROUP_TYPE   = 2'd2;

    // Reset values of the type code registers.
    localparam logic [15:0] RESET_VERSION_TYPE = 16'd1;
    localparam logic [15:0] RESET_SIZE_TYPE    = 16'd2;
    localparam logic [15:0] RESET_GROUP_TYPE   = 16'd3;

    // Header byte positions of the two length bytes and of the value section of a record.
    localparam logic [2:0] POS_VALUE = 3'd4;
    localparam logic [2:0] POS_LEN_HI = 3'd2;
    localparam logic [2:0] POS_LEN_LO = 3'd3;

    // Group address kinds and the record lengths that go with them.
    localparam logic [7:0]  KIND_ADDR4 = 8'd1;
    localparam logic [7:0]  KIND_ADDR16 = 8'd2;
    localparam logic [15:0] LEN_ADDR4 = 16'd5;
    localparam logic [15:0] LEN_ADDR16 = 16'd17;
    localparam logic [15:0] LEN_SIZE = 16'd2;
    localparam logic [15:0] ADDR_BYTES_MAX = 16'd16;

    // Parse status codes, also used as the finished code of the parser.
    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_PARSING   = 2'd2
    } status_t;

    // Record classes.
    typedef enum logic [1:0] {
        CLASS_OTHER   = 2'd0,
        CLASS_VERSION = 2'd1,
        CLASS_SIZE    = 2'd2,
        CLASS_GROUP   = 2'd3
    } rec_class_t;

    // Type code registers as seen by the parser.
    typedef struct packed {
        logic [15:0] version_type;
        logic [15:0] size_type;
        logic [15:0] group_type;
    } type_codes_t;

    // One result item.
    typedef struct packed {
        logic [63:0] group_addr_low;
        logic [63:0] group_addr_high;
        logic [1:0]  group_kind;
        logic [15:0] reply_size;
        logic        version_requested;
        logic [1:0]  parse_status;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);
    localparam int TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    // Maps a record type to its class; earlier registers win on equal codes.
    function automatic rec_class_t classify(input logic [15:0] t, input type_codes_t codes);
        rec_class_t c;
        if (t == codes.version_type) begin
            c = CLASS_VERSION;
        end else if (t == codes.size_type) begin
            c = CLASS_SIZE;
        end else if (t == codes.group_type) begin
            c = CLASS_GROUP;
        end else begin
            c = CLASS_OTHER;
        end
        return c;
    endfunction

endpackage

@@ src/tlvqp_cfg.sv @@
// Type code registers of the TLV query parser with their write port.
module tlvqp_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_addr,
    input  logic [15:0]                cfg_wr_data,
    output tlvqp_pkg::type_codes_t     codes
);

    tlvqp_pkg::type_codes_t codes_reg;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.version_type <= tlvqp_pkg::RESET_VERSION_TYPE;
            codes_reg.size_type    <= tlvqp_pkg::RESET_SIZE_TYPE;
            codes_reg.group_type   <= tlvqp_pkg::RESET_GROUP_TYPE;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tlvqp_pkg::REG_VERSION_TYPE: codes_reg.version_type <= cfg_wr_data;
                tlvqp_pkg::REG_SIZE_TYPE:    codes_reg.size_type <= cfg_wr_data;
                tlvqp_pkg::REG_GROUP_TYPE:   codes_reg.group_type <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign codes = codes_reg;

endmodule

@@ src/tlvqp_core.sv @@
// Per-byte parse state of the TLV query parser and the result it yields.
module tlvqp_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [7:0]                 message_byte,
    input  logic                       last_byte,
    input  tlvqp_pkg::type_codes_t     codes,
    output tlvqp_pkg::result_t         result
);

    logic [2:0]          pos_reg, pos_next;
    logic [15:0]         type_reg, type_next;
    logic [15:0]         len_reg, len_next;
    logic [15:0]         seen_reg, seen_next;
    logic [7:0]          kind_reg, kind_next;
    logic [15:0]         size_cap_reg, size_cap_next;
    logic [15:0]         size_held_reg, size_held_next;
    logic [63:0]         addr_hi_reg, addr_hi_next;
    logic [63:0]         addr_lo_reg, addr_lo_next;
    logic                ver_reg, ver_next;
    tlvqp_pkg::status_t  fin_reg, fin_next;
    tlvqp_pkg::rec_class_t cls_cur;
    tlvqp_pkg::rec_class_t cls_next;
    logic                do_finish;
    tlvqp_pkg::status_t  status;

    assign cls_cur  = tlvqp_pkg::classify(type_reg, codes);
    assign cls_next = tlvqp_pkg::classify(type_next, codes);

    // Next state for one byte: header assembly, value capture, record close.
    always_comb begin
        pos_next       = pos_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        seen_next      = seen_reg;
        kind_next      = kind_reg;
        size_cap_next  = size_cap_reg;
        size_held_next = size_held_reg;
        addr_hi_next   = addr_hi_reg;
        addr_lo_next   = addr_lo_reg;
        ver_next       = ver_reg;
        fin_next       = fin_reg;
        do_finish      = 1'b0;

        if (fin_reg == tlvqp_pkg::STATUS_PARSING) begin
            if (pos_reg != tlvqp_pkg::POS_VALUE) begin
                // Header bytes: type then length, both big-endian.
                if (pos_reg < tlvqp_pkg::POS_LEN_HI) begin
                    type_next = {type_reg[7:0], message_byte};
                end else begin
                    len_next = {len_reg[7:0], message_byte};
                end
                pos_next = pos_reg + 3'd1;
                if (pos_reg == tlvqp_pkg::POS_LEN_LO) begin
                    seen_next     = '0;
                    kind_next     = '0;
                    size_cap_next = '0;
                    addr_hi_next  = '0;
                    addr_lo_next  = '0;
                    do_finish     = (len_next == '0);
                end
            end else begin
                // Value bytes: capture what the record class needs.
                unique case (cls_cur)
                    tlvqp_pkg::CLASS_SIZE: begin
                        size_cap_next = {size_cap_reg[7:0], message_byte};
                    end
                    tlvqp_pkg::CLASS_GROUP: begin
                        if (seen_reg == '0) begin
                            kind_next = message_byte;
                        end else if (seen_reg <= tlvqp_pkg::ADDR_BYTES_MAX) begin
                            addr_hi_next = {addr_hi_reg[55:0], addr_lo_reg[63:56]};
                            addr_lo_next = {addr_lo_reg[55:0], message_byte};
                        end
                    end
                    default: ;
                endcase
                seen_next = seen_reg + 16'd1;
                do_finish = (seen_next == len_reg);
            end

            // Close the record and check its length and kind.
            if (do_finish) begin
                pos_next = '0;
                unique case (cls_next)
                    tlvqp_pkg::CLASS_VERSION: ver_next = 1'b1;
                    tlvqp_pkg::CLASS_SIZE: begin
                        if (len_next != tlvqp_pkg::LEN_SIZE) begin
                            fin_next = tlvqp_pkg::STATUS_MALFORMED;
                        end else begin
                            size_held_next = size_cap_next;
                        end
                    end
                    tlvqp_pkg::CLASS_GROUP: begin
                        if ((kind_next == tlvqp_pkg::KIND_ADDR4 &&
                             len_next == tlvqp_pkg::LEN_ADDR4) ||
                            (kind_next == tlvqp_pkg::KIND_ADDR16 &&
                             len_next == tlvqp_pkg::LEN_ADDR16)) begin
                            fin_next = tlvqp_pkg::STATUS_FOUND;
                        end else begin
                            fin_next = tlvqp_pkg::STATUS_MALFORMED;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Status as seen at the last byte: a value cut short is malformed.
    always_comb begin
        if (fin_next != tlvqp_pkg::STATUS_PARSING) begin
            status = fin_next;
        end else if (pos_next == tlvqp_pkg::POS_VALUE) begin
            status = tlvqp_pkg::STATUS_MALFORMED;
        end else begin
            status = tlvqp_pkg::STATUS_PARSING;
        end
    end

    // Result fields; group data only on success.
    always_comb begin
        result.parse_status      = status;
        result.version_requested = ver_next;
        result.reply_size        = size_held_next;
        if (status == tlvqp_pkg::STATUS_FOUND) begin
            result.group_kind      = kind_next[1:0];
            result.group_addr_high = addr_hi_next;
            result.group_addr_low  = addr_lo_next;
        end else begin
            result.group_kind      = '0;
            result.group_addr_high = '0;
            result.group_addr_low  = '0;
        end
    end

    // State registers; every query starts from a clean state.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            pos_reg       <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            seen_reg      <= '0;
            kind_reg      <= '0;
            size_cap_reg  <= '0;
            size_held_reg <= '0;
            addr_hi_reg   <= '0;
            addr_lo_reg   <= '0;
            ver_reg       <= 1'b0;
            fin_reg       <= tlvqp_pkg::STATUS_PARSING;
        end else if (step) begin
            pos_reg       <= pos_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            seen_reg      <= seen_next;
            kind_reg      <= kind_next;
            size_cap_reg  <= size_cap_next;
            size_held_reg <= size_held_next;
            addr_hi_reg   <= addr_hi_next;
            addr_lo_reg   <= addr_lo_next;
            ver_reg       <= ver_next;
            fin_reg       <= fin_next;
        end
    end

endmodule

@@ src/tlv_query_parser.sv @@
// Top level of the TLV query parser: input register, parse core, result register.
//
// The s_ channel takes one query body byte per request, with s_tlast on the
// final byte of the body. Records are a 16-bit big-endian type, a 16-bit
// big-endian length and the value. At the final byte one result request
// leaves on the m_ channel; no other byte produces a result.
//
// The type codes of the version request, reply size and group records sit in
// three registers written through cfg_wr_en / cfg_addr / cfg_wr_data; they are
// to be written only while no query is in flight, which the block does not enforce.
//
// Throughput is one byte per cycle while no final byte is held back. A byte is
// held in the input register and then updates the parse state; the result of
// a final byte goes into the result register, which drives m_tdata, as that
// byte leaves the input register. The single result register stalls only final
// bytes: when m_tready is low and a result is waiting, other bytes still flow
// and a final byte waits in the input register, which then holds off s_tready.
//
// aresetn (synchronous, active low) empties both registers, clears the
// parse state and restores the type codes 1, 2 and 3.
module tlv_query_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] message_byte
    input  logic                              s_tlast,   // last_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] parse_status, [2] version_requested, [18:3] reply_size,
    // [20:19] group_kind, [84:21] group_addr_high, [148:85] group_addr_low,
    // [151:149] zero
    output logic [tlvqp_pkg::TDATA_BITS-1:0]  m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_addr,
    input  logic [15:0]                       cfg_wr_data
);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_last_reg;
    logic                    out_valid_reg;
    tlvqp_pkg::result_t      out_data_reg;
    logic                    out_free;
    logic                    advance;
    tlvqp_pkg::type_codes_t  codes;
    tlvqp_pkg::result_t      result;

    tlvqp_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .codes       (codes)
    );

    // A byte moves on unless it is final and the result register is full and not read.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tlvqp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .message_byte (in_byte_reg),
        .last_byte    (in_last_reg),
        .codes        (codes),
        .result       (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tlvqp_pkg::TDATA_BITS - tlvqp_pkg::RESULT_BITS){1'b0}}, out_data_reg};

endmodule
